// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while reset is low.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/afs_pkg.sv =====
`timescale 1ns / 1ps

package afs_pkg;

   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int COUNT_W       = 7;
   localparam int PERIOD_W      = 32;
   localparam int SCALE_W       = 16;
   localparam int LOOP_W        = 2;
   localparam int DELTA_W       = 16;
   localparam int FRAME_INDEX_W = 6;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_COUNT      = 3'd0,
      CSR_FRAME_PERIOD     = 3'd1,
      CSR_PLAY_SCALE       = 3'd2,
      CSR_LOOP_MODE        = 3'd3,
      CSR_START_REVERSE    = 3'd4,
      CSR_NOTIFY_MASK      = 3'd5,
      CSR_END_EVENT_ENABLE = 3'd6,
      CSR_NEXT_ANIM_ENABLE = 3'd7
   } csr_index_type;

   typedef enum logic [LOOP_W-1:0] {
      LOOP_NONE   = 2'd0,
      LOOP_NORMAL = 2'd1,
      LOOP_ZIGZAG = 2'd2
   } loop_mode_type;

   localparam logic ACTION_TICK    = 1'b0;
   localparam logic ACTION_RESTART = 1'b1;

   localparam logic [COUNT_W-1:0]  FRAME_COUNT_RESET  = 7'd1;
   localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RESET = 32'd65536;
   localparam logic [SCALE_W-1:0]  PLAY_SCALE_RESET   = 16'd256;

endpackage

// ===== src/animation_frame_sequencer_core.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Content
// req_    | in        | tdata: delta_time[15:0]; tuser: action (0 tick, 1 restart)
// rsp_    | out       | tdata: frame_index, notify_fire, end_fire, reached_end,
//         |           |        switch_request, playing_backward, zero fill
// csr_    | in        | write enable, register index, 64-bit write data
//
// A transaction is held in the input register, then its result in the result register.
// One transaction is accepted every cycle unless the result stalls; the input register, the
// multiply-accumulate and frame step logic, and the result register form the path.
// A stalled result register holds the input register, which then drops req_tready.
// Reset is synchronous and loads the register reset values and clears the state.

module animation_frame_sequencer_core #(
   parameter int MAX_FRAMES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [afs_pkg::REQ_DATA_W-1:0]  req_tdata,  // delta_time[15:0]
   input  logic                            req_tuser,  // action
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [afs_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // frame_index[5:0], notify_fire,
                                                       // end_fire, reached_end,
                                                       // switch_request,
                                                       // playing_backward, zeros
   input  logic                            csr_wen,
   input  logic [afs_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [afs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import afs_pkg::*;

`include "assert_macros.svh"

   localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAMES);

   logic [COUNT_W-1:0]    frame_count_ff;
   logic [PERIOD_W-1:0]   frame_period_ff;
   logic [SCALE_W-1:0]    play_scale_ff;
   logic [LOOP_W-1:0]     loop_mode_ff;
   logic [MAX_FRAMES-1:0] notify_mask_ff;
   logic                  end_event_enable_ff;
   logic                  next_anim_enable_ff;

   logic                  in_valid_ff;
   logic                  in_action_ff;
   logic [DELTA_W-1:0]    in_delta_ff;

   logic [PERIOD_W-1:0]   time_accum_ff, time_accum_in;
   logic [FRAME_W-1:0]    frame_ff, frame_in;
   logic                  backward_ff, backward_in;
   logic                  end_done_ff, end_done_in;
   logic [MAX_FRAMES-1:0] notify_done_ff, notify_done_in;

   logic                  rsp_valid_ff;
   logic [FRAME_W-1:0]    rsp_frame_ff;
   logic                  rsp_notify_ff, rsp_notify_in;
   logic                  rsp_end_fire_ff, rsp_end_fire_in;
   logic                  rsp_at_end_ff, rsp_at_end_in;
   logic                  rsp_switch_ff, rsp_switch_in;
   logic                  rsp_backward_ff;

   logic                  advance;
   logic [COUNT_W-1:0]    eff_count;
   logic [COUNT_W-1:0]    last_wide;
   logic [FRAME_W-1:0]    last_frame;
   logic [PERIOD_W-1:0]   product;
   logic [PERIOD_W:0]     sum;
   logic [PERIOD_W-1:0]   accum_sat;
   logic [FRAME_W-1:0]    frame_base;
   logic [FRAME_W-1:0]    frame_step;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      eff_count = frame_count_ff;
      if (frame_count_ff == '0) begin
         eff_count = COUNT_W'(1);
      end else if (frame_count_ff > MAX_COUNT) begin
         eff_count = MAX_COUNT;
      end
      last_wide  = eff_count - COUNT_W'(1);
      last_frame = last_wide[FRAME_W-1:0];
   end

   always_comb begin
      product   = PERIOD_W'(in_delta_ff) * PERIOD_W'(play_scale_ff);
      sum       = {1'b0, time_accum_ff} + (PERIOD_W + 1)'(product[PERIOD_W-1:8]);
      accum_sat = sum[PERIOD_W] ? '1 : sum[PERIOD_W-1:0];
      frame_base = (frame_ff > last_frame) ? last_frame : frame_ff;

      time_accum_in   = time_accum_ff;
      frame_in        = frame_ff;
      backward_in     = backward_ff;
      end_done_in     = end_done_ff;
      notify_done_in  = notify_done_ff;
      rsp_notify_in   = 1'b0;
      rsp_end_fire_in = 1'b0;
      rsp_at_end_in   = 1'b0;
      rsp_switch_in   = 1'b0;
      frame_step      = frame_base;

      if (in_action_ff == ACTION_RESTART) begin
         time_accum_in  = '0;
         frame_in       = backward_ff ? last_frame : '0;
         notify_done_in = '0;
         end_done_in    = 1'b0;
      end else begin
         time_accum_in = accum_sat;
         if (accum_sat >= frame_period_ff) begin
            time_accum_in = accum_sat - frame_period_ff;
            if (backward_ff) begin
               if (frame_base == '0) begin
                  rsp_at_end_in = 1'b1;
               end else begin
                  frame_step = frame_base - FRAME_W'(1);
               end
            end else begin
               if (frame_base >= last_frame) begin
                  frame_step    = last_frame;
                  rsp_at_end_in = 1'b1;
               end else begin
                  frame_step = frame_base + FRAME_W'(1);
               end
            end
         end
         frame_in = frame_step;

         if (notify_mask_ff[frame_step] && !notify_done_ff[frame_step]) begin
            rsp_notify_in              = 1'b1;
            notify_done_in[frame_step] = 1'b1;
         end

         if (rsp_at_end_in) begin
            if (end_event_enable_ff && !end_done_ff) begin
               end_done_in     = 1'b1;
               rsp_end_fire_in = 1'b1;
            end
            unique case (loop_mode_ff)
               LOOP_NORMAL: begin
                  frame_in       = backward_ff ? last_frame : '0;
                  notify_done_in = '0;
                  end_done_in    = 1'b0;
               end
               LOOP_ZIGZAG: begin
                  backward_in    = !backward_ff;
                  notify_done_in = '0;
                  end_done_in    = 1'b0;
               end
               default: begin
               end
            endcase
            rsp_switch_in = next_anim_enable_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff      <= FRAME_COUNT_RESET;
         frame_period_ff     <= FRAME_PERIOD_RESET;
         play_scale_ff       <= PLAY_SCALE_RESET;
         loop_mode_ff        <= LOOP_NONE;
         notify_mask_ff      <= '0;
         end_event_enable_ff <= 1'b0;
         next_anim_enable_ff <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_FRAME_COUNT:      frame_count_ff      <= csr_wdata[COUNT_W-1:0];
            CSR_FRAME_PERIOD:     frame_period_ff     <= csr_wdata[PERIOD_W-1:0];
            CSR_PLAY_SCALE:       play_scale_ff       <= csr_wdata[SCALE_W-1:0];
            CSR_LOOP_MODE:        loop_mode_ff        <= csr_wdata[LOOP_W-1:0];
            CSR_NOTIFY_MASK:      notify_mask_ff      <= csr_wdata[MAX_FRAMES-1:0];
            CSR_END_EVENT_ENABLE: end_event_enable_ff <= csr_wdata[0];
            CSR_NEXT_ANIM_ENABLE: next_anim_enable_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_accum_ff  <= '0;
         frame_ff       <= '0;
         backward_ff    <= 1'b0;
         end_done_ff    <= 1'b0;
         notify_done_ff <= '0;
      end else if (csr_wen && (csr_addr == CSR_START_REVERSE)) begin
         backward_ff <= csr_wdata[0];
      end else if (advance) begin
         time_accum_ff  <= time_accum_in;
         frame_ff       <= frame_in;
         backward_ff    <= backward_in;
         end_done_ff    <= end_done_in;
         notify_done_ff <= notify_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_action_ff <= req_tuser;
         in_delta_ff  <= req_tdata[DELTA_W-1:0];
      end
      if (advance) begin
         rsp_frame_ff    <= frame_in;
         rsp_notify_ff   <= rsp_notify_in;
         rsp_end_fire_ff <= rsp_end_fire_in;
         rsp_at_end_ff   <= rsp_at_end_in;
         rsp_switch_ff   <= rsp_switch_in;
         rsp_backward_ff <= backward_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_backward_ff, rsp_switch_ff, rsp_at_end_ff,
                        rsp_end_fire_ff, rsp_notify_ff, FRAME_INDEX_W'(rsp_frame_ff)};

   `ASSERT_CLK(a_end_fire_needs_end, clock, reset,
      rsp_valid_ff |-> (!rsp_end_fire_ff || rsp_at_end_ff), "end event without an end")
   `ASSERT_CLK(a_switch_needs_end, clock, reset,
      rsp_valid_ff |-> (!rsp_switch_ff || rsp_at_end_ff), "switch request without an end")
   `ASSERT_CLK(a_advance_gives_result, clock, reset,
      advance |=> rsp_valid_ff, "processed transaction left no result")
   `ASSERT_CLK(a_stall_only_when_full, clock, reset,
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready),
      "input stalled without a full pipeline")
   `ASSERT_ALWAYS(a_reset_empties, clock,
      reset |=> (!rsp_valid_ff && !in_valid_ff), "pipeline not empty after reset")

endmodule
